/* rtl/core/lprd_pkg.sv */
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants of the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned FieldW  = 2;

  // output tdata layout, lowest bit first
  localparam int unsigned TdByteLsb  = 0;
  localparam int unsigned TdArgLsb   = TdByteLsb + ByteW;
  localparam int unsigned TdEndBit   = TdArgLsb + WordW;
  localparam int unsigned TdCountLsb = TdEndBit + 1;
  localparam int unsigned TdErrLsb   = TdCountLsb + WordW;
  localparam int unsigned TdUsedW    = TdErrLsb + ErrW;
  localparam int unsigned OutTdataW  = ((TdUsedW + 7) / 8) * 8;
  localparam int unsigned TdPadW     = OutTdataW - TdUsedW;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMaxFrameBytes = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxArguments  = 1'd1;

  localparam logic [WordW-1:0] MaxFrameBytesRst = 32'd33554432;
  localparam logic [WordW-1:0] MaxArgumentsRst  = 32'd200000;
  localparam logic [WordW-1:0] FieldBytes       = 32'd4;

  typedef enum logic [2:0] {
    PH_FRAME_LEN,
    PH_ARG_COUNT,
    PH_ARG_LEN,
    PH_ARG_DATA,
    PH_ERROR
  } phase_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE          = 3'd0,
    ERR_TOO_LONG      = 3'd1,
    ERR_TOO_MANY_ARGS = 3'd2,
    ERR_OVERRUN       = 3'd3,
    ERR_TRAILING      = 3'd4
  } err_e;

  typedef struct packed {
    logic [WordW-1:0] max_frame_bytes;
    logic [WordW-1:0] max_arguments;
  } lprd_limits_t;

  typedef struct packed {
    err_e             error_code;
    logic [WordW-1:0] frame_arg_count;
    logic             frame_done;
    logic             arg_end;
    logic [WordW-1:0] arg_number;
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
  } lprd_result_t;

endpackage

/* rtl/core/length_prefixed_request_deframer_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_top
// Splits a length-prefixed request byte stream into tagged argument bytes.
//
//   channel  dir  payload
//   s_axis   in   tdata = in_byte
//   m_axis   out  tdata/tlast/tuser = one result per request byte
//   cfg      in   write of max_frame_bytes (0) or max_arguments (1)
//
// one request byte per cycle unless m_axis_tready stalls, via in and out registers
// the parser updates all counters together on each step, which sets the rate
// s_axis_tready follows m_axis_tready combinationally through both registers
// reset clears the parser state, limits go to their defaults
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lprd_pkg::ByteW-1:0]     s_axis_tdata,   // in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // data_byte, arg_number, arg_end, frame_arg_count, error_code
  output logic [lprd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,   // frame_done
  output logic                           m_axis_tuser,   // data_valid
  input  logic                           cfg_we_i,
  input  logic [lprd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lprd_pkg::WordW-1:0]     cfg_wdata_i
);
  import lprd_pkg::*;

  lprd_limits_t     limits_q, limits_d;
  logic             in_valid, out_ready, step;
  logic [ByteW-1:0] in_byte;
  lprd_result_t     result;
  err_e             sticky_err;

  always_comb begin
    limits_d = limits_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMaxFrameBytes: limits_d.max_frame_bytes = cfg_wdata_i;
        CfgMaxArguments:  limits_d.max_arguments   = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.max_frame_bytes <= MaxFrameBytesRst;
      limits_q.max_arguments   <= MaxArgumentsRst;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign step = in_valid && out_ready;

  lprd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .take_i    (out_ready),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  lprd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte),
    .limits_i     (limits_q),
    .result_o     (result),
    .sticky_err_o (sticky_err)
  );

  lprd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .result_i  (result),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_user_o  (m_axis_tuser)
  );

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_err != ERR_NONE |=> sticky_err == $past(sticky_err))
    else $error("sticky error changed");

  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[TdErrLsb +: ErrW] == ERR_NONE)
    else $error("data byte with error");

  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[TdErrLsb +: ErrW] == ERR_NONE)
    else $error("frame end together with error");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && result.error_code != ERR_NONE |->
      !result.data_valid && !result.arg_end && !result.frame_done)
    else $error("errored result carries payload");

endmodule

/* rtl/core/lprd_in_reg.sv */
// ----------------------------------------------------------------------------
// lprd_in_reg
// Input register for request bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module lprd_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [lprd_pkg::ByteW-1:0] s_data_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [lprd_pkg::ByteW-1:0] data_o
);
  import lprd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] data_q;
  logic             load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lprd_parser.sv */
// ----------------------------------------------------------------------------
// lprd_parser
// Frame parser state machine: one request byte per step, one result per step.
// ----------------------------------------------------------------------------
module lprd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [lprd_pkg::ByteW-1:0] byte_i,
  input  lprd_pkg::lprd_limits_t     limits_i,
  output lprd_pkg::lprd_result_t     result_o,
  output lprd_pkg::err_e             sticky_err_o
);
  import lprd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [FieldW-1:0]  pos_q, pos_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [WordW-1:0]   fbl_q, fbl_d;
  logic [WordW-1:0]   args_q, args_d;
  logic [WordW-1:0]   abl_q, abl_d;
  logic [WordW-1:0]   cur_q, cur_d;
  err_e               err_q, err_d;

  logic [WordW-1:0]   fbl_dec, abl_dec, acc_new;
  logic [FieldW-1:0]  pos_new;
  logic               finish, boundary;
  logic               ev_data, ev_end, ev_done;

  assign fbl_dec = (phase_q != PH_FRAME_LEN && fbl_q != '0) ? fbl_q - WordW'(1) : fbl_q;
  assign abl_dec = (abl_q != '0) ? abl_q - WordW'(1) : abl_q;
  assign acc_new = {acc_q[WordW-ByteW-1:0], byte_i};
  assign pos_new = pos_q + FieldW'(1);

  // next state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    fbl_d    = fbl_q;
    args_d   = args_q;
    abl_d    = abl_q;
    cur_d    = cur_q;
    err_d    = err_q;
    finish   = 1'b0;
    boundary = 1'b0;
    ev_data  = 1'b0;
    ev_end   = 1'b0;
    ev_done  = 1'b0;
    if (step_i && phase_q != PH_ERROR) begin
      fbl_d = fbl_dec;
      if (phase_q == PH_ARG_DATA) begin
        ev_data = 1'b1;
        abl_d   = abl_dec;
        if (abl_dec == '0) begin
          finish = 1'b1;
        end
      end else begin
        acc_d = acc_new;
        pos_d = pos_new;
        if (pos_new == '0) begin
          acc_d = '0;
          case (phase_q)
            PH_FRAME_LEN: begin
              if (acc_new > limits_i.max_frame_bytes) begin
                err_d   = ERR_TOO_LONG;
                phase_d = PH_ERROR;
              end else if (acc_new < FieldBytes) begin
                err_d   = ERR_OVERRUN;
                phase_d = PH_ERROR;
              end else begin
                fbl_d   = acc_new;
                cur_d   = '0;
                phase_d = PH_ARG_COUNT;
              end
            end
            PH_ARG_COUNT: begin
              if (acc_new > limits_i.max_arguments) begin
                err_d   = ERR_TOO_MANY_ARGS;
                phase_d = PH_ERROR;
              end else begin
                args_d   = acc_new;
                boundary = 1'b1;
              end
            end
            PH_ARG_LEN: begin
              if (acc_new > fbl_dec) begin
                err_d   = ERR_OVERRUN;
                phase_d = PH_ERROR;
              end else if (acc_new == '0) begin
                finish = 1'b1;
              end else begin
                abl_d   = acc_new;
                phase_d = PH_ARG_DATA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      if (finish) begin
        ev_end   = 1'b1;
        cur_d    = cur_q + WordW'(1);
        args_d   = args_q - WordW'(1);
        boundary = 1'b1;
      end
      if (boundary) begin
        if (args_d == '0) begin
          if (fbl_dec == '0) begin
            ev_done = 1'b1;
            phase_d = PH_FRAME_LEN;
          end else begin
            err_d   = ERR_TRAILING;
            phase_d = PH_ERROR;
          end
        end else if (fbl_dec < FieldBytes) begin
          err_d   = ERR_OVERRUN;
          phase_d = PH_ERROR;
        end else begin
          phase_d = PH_ARG_LEN;
        end
      end
    end
  end

  // result
  always_comb begin
    result_o                 = '0;
    result_o.error_code      = err_d;
    if (phase_d != PH_ERROR) begin
      result_o.data_valid      = ev_data;
      result_o.data_byte       = ev_data ? byte_i : '0;
      result_o.arg_number      = (ev_data || ev_end) ? cur_q : '0;
      result_o.arg_end         = ev_end;
      result_o.frame_done      = ev_done;
      result_o.frame_arg_count = ev_done ? cur_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FRAME_LEN;
      pos_q   <= '0;
      acc_q   <= '0;
      fbl_q   <= '0;
      args_q  <= '0;
      abl_q   <= '0;
      cur_q   <= '0;
      err_q   <= ERR_NONE;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      fbl_q   <= fbl_d;
      args_q  <= args_d;
      abl_q   <= abl_d;
      cur_q   <= cur_d;
      err_q   <= err_d;
    end
  end

  assign sticky_err_o = err_q;

endmodule

/* rtl/core/lprd_out_reg.sv */
// ----------------------------------------------------------------------------
// lprd_out_reg
// Result register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lprd_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  lprd_pkg::lprd_result_t         result_i,
  output logic                           ready_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [lprd_pkg::OutTdataW-1:0] m_data_o,
  output logic                           m_last_o,
  output logic                           m_user_o
);
  import lprd_pkg::*;

  logic         valid_q, valid_d;
  lprd_result_t res_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {{TdPadW{1'b0}}, res_q.error_code, res_q.frame_arg_count,
                      res_q.arg_end, res_q.arg_number, res_q.data_byte};
  assign m_last_o  = res_q.frame_done;
  assign m_user_o  = res_q.data_valid;

endmodule

/* dv/length_prefixed_request_deframer_top_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_top_tb
// Sends framed request byte streams, and ends with one sticky error and noise.
// A tracker predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module length_prefixed_request_deframer_top_tb;
  import lprd_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandomBytes = 1000;

  class deframe_tracker;
    phase_e           phase;
    logic [1:0]       field_pos;
    logic [WordW-1:0] accum;
    logic [WordW-1:0] frame_left;
    logic [WordW-1:0] args_left;
    logic [WordW-1:0] arg_left;
    logic [WordW-1:0] cur_arg;
    logic [WordW-1:0] max_frame;
    logic [WordW-1:0] arg_limit;
    err_e             err;
    lprd_result_t     pending_results[$];
    int               mismatches;

    function new();
      phase = PH_FRAME_LEN;
      field_pos = '0;
      accum = '0;
      frame_left = '0;
      args_left = '0;
      arg_left = '0;
      cur_arg = '0;
      max_frame = MaxFrameBytesRst;
      arg_limit = MaxArgumentsRst;
      err = ERR_NONE;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
      if (idx == CfgMaxFrameBytes) begin
        max_frame = val;
      end else begin
        arg_limit = val;
      end
    endfunction

    function void set_error(err_e code);
      err = code;
      phase = PH_ERROR;
    endfunction

    function void settle_boundary(inout lprd_result_t r);
      if (args_left == 0) begin
        if (frame_left == 0) begin
          r.frame_done = 1'b1;
          r.frame_arg_count = cur_arg;
          phase = PH_FRAME_LEN;
        end else begin
          set_error(ERR_TRAILING);
        end
      end else if (frame_left < FieldBytes) begin
        set_error(ERR_OVERRUN);
      end else begin
        phase = PH_ARG_LEN;
      end
    endfunction

    function void end_argument(inout lprd_result_t r);
      r.arg_end = 1'b1;
      r.arg_number = cur_arg;
      cur_arg = cur_arg + 1;
      args_left = args_left - 1;
      settle_boundary(r);
    endfunction

    function void note_request(logic [ByteW-1:0] b);
      lprd_result_t     r;
      logic [WordW-1:0] v;
      r = '0;
      if (phase != PH_ERROR) begin
        if (phase != PH_FRAME_LEN && frame_left != 0) frame_left = frame_left - 1;
        if (phase == PH_ARG_DATA) begin
          r.data_valid = 1'b1;
          r.data_byte = b;
          r.arg_number = cur_arg;
          if (arg_left != 0) arg_left = arg_left - 1;
          if (arg_left == 0) end_argument(r);
        end else begin
          accum = {accum[WordW-ByteW-1:0], b};
          field_pos = field_pos + 2'd1;
          if (field_pos == 2'd0) begin
            v = accum;
            accum = '0;
            case (phase)
              PH_FRAME_LEN: begin
                if (v > max_frame) begin
                  set_error(ERR_TOO_LONG);
                end else if (v < FieldBytes) begin
                  set_error(ERR_OVERRUN);
                end else begin
                  frame_left = v;
                  cur_arg = '0;
                  phase = PH_ARG_COUNT;
                end
              end
              PH_ARG_COUNT: begin
                if (v > arg_limit) begin
                  set_error(ERR_TOO_MANY_ARGS);
                end else begin
                  args_left = v;
                  settle_boundary(r);
                end
              end
              default: begin
                if (v > frame_left) begin
                  set_error(ERR_OVERRUN);
                end else if (v == 0) begin
                  end_argument(r);
                end else begin
                  arg_left = v;
                  phase = PH_ARG_DATA;
                end
              end
            endcase
          end
        end
      end
      if (phase == PH_ERROR) begin
        r = '0;
        r.error_code = err;
      end
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [OutTdataW-1:0] td, logic last, logic user);
      lprd_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no request pending", td[WordW-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (user !== want.data_valid) report("data_valid", user, want.data_valid);
        if (td[TdByteLsb +: ByteW] !== want.data_byte)
          report("data_byte", td[TdByteLsb +: ByteW], want.data_byte);
        if (td[TdArgLsb +: WordW] !== want.arg_number)
          report("arg_number", td[TdArgLsb +: WordW], want.arg_number);
        if (td[TdEndBit] !== want.arg_end) report("arg_end", td[TdEndBit], want.arg_end);
        if (last !== want.frame_done) report("frame_done", last, want.frame_done);
        if (td[TdCountLsb +: WordW] !== want.frame_arg_count)
          report("frame_arg_count", td[TdCountLsb +: WordW], want.frame_arg_count);
        if (td[TdErrLsb +: ErrW] !== want.error_code)
          report("error_code", td[TdErrLsb +: ErrW], want.error_code);
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteW-1:0]      s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [WordW-1:0]      cfg_wdata_i = '0;

  deframe_tracker book = new();
  int unsigned    burst_left = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    idle_cycles = 0;
  bit             hold_off_pending = 1'b0;
  int unsigned    hold = 0;
  int unsigned    seg_left = 0;
  int unsigned    mode = 0;

  length_prefixed_request_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("length_prefixed_request_deframer_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold = HoldCycles;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (mode == 0) || ($urandom_range(0, mode) != 0);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [WordW-1:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (book.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    book.set_limit(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic pick_limits();
    write_limit(CfgMaxFrameBytes, $urandom_range(64, 160));
    write_limit(CfgMaxArguments, $urandom_range(2, 12));
  endtask

  // well-formed frame within the current limits, sometimes filling them exactly
  task automatic send_frame();
    int unsigned n;
    int unsigned budget;
    int unsigned cap;
    int unsigned body;
    int unsigned lens[$];
    n = ($urandom_range(0, 7) == 0) ? book.arg_limit : $urandom_range(0, book.arg_limit);
    budget = book.max_frame - 4 - 4 * n;
    for (int i = 0; i < n; i++) begin
      cap = ($urandom_range(0, 9) == 0) ? budget : ((budget < 7) ? budget : 7);
      lens.push_back($urandom_range(0, cap));
      budget -= lens[i];
    end
    if (n != 0 && $urandom_range(0, 5) == 0) lens[n-1] += budget;
    body = 4;
    foreach (lens[i]) body += 4 + lens[i];
    send_word(body);
    send_word(n);
    foreach (lens[i]) begin
      send_word(lens[i]);
      repeat (lens[i]) send_byte($urandom_range(0, 255));
    end
  endtask

  initial begin
    int unsigned frames;
    int unsigned extra;
    err_e        kind;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // widest limits; zero-count frame, then an empty and a one-byte argument
    write_limit(CfgMaxFrameBytes, '1);
    write_limit(CfgMaxArguments, '1);
    send_word(32'd4);
    send_word(32'd0);
    send_word(32'd13);
    send_word(32'd2);
    send_word(32'd0);
    send_word(32'd1);
    send_byte(8'hFF);
    drain_results();

    pick_limits();
    hold_off_pending = 1'b1;
    frames = 0;
    while (bytes_sent < RandomBytes) begin
      send_frame();
      frames++;
      if (frames % 8 == 0) begin
        drain_results();
        pick_limits();
      end
    end
    drain_results();

    // one sticky error, then noise that must be ignored
    kind = err_e'($urandom_range(ERR_TOO_LONG, ERR_TRAILING));
    extra = $urandom_range(1, 20);
    case (kind)
      ERR_TOO_LONG: begin
        write_limit(CfgMaxFrameBytes, '0);
        send_word($urandom_range(1, 32'hFFFF_FFFF));
      end
      ERR_TOO_MANY_ARGS: begin
        write_limit(CfgMaxArguments, '0);
        send_word(32'd8);
        send_word($urandom_range(1, 32'hFFFF_FFFF));
      end
      ERR_OVERRUN: begin
        case ($urandom_range(0, 2))
          0: send_word($urandom_range(0, 3));
          1: begin
            send_word(32'd4);
            send_word(32'd1);
          end
          default: begin
            send_word(32'd8);
            send_word(32'd1);
            send_word($urandom_range(1, 32'hFFFF_FFFF));
          end
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(4 + extra);
          send_word(32'd0);
        end else begin
          send_word(9 + extra);
          send_word(32'd1);
          send_word(32'd1);
          send_byte($urandom_range(0, 255));
        end
      end
    endcase
    repeat (40) send_byte($urandom_range(0, 255));
    drain_results();
    repeat (8) @(posedge clk_i);

    if (book.mismatches == 0) begin
      $display("length_prefixed_request_deframer_top_tb passed");
    end else begin
      $display("length_prefixed_request_deframer_top_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lprd_pkg.sv
rtl/core/lprd_in_reg.sv
rtl/core/lprd_parser.sv
rtl/core/lprd_out_reg.sv
rtl/core/length_prefixed_request_deframer_top.sv
dv/length_prefixed_request_deframer_top_tb.sv
